[src/assert_macros.svh]
// Assertion macros used by the checker file of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked implication from an antecedent to a consequent on the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons))

`endif

[src/epx_pkg.sv]
// Shared types and constants for the encoder position extender.
// No dependencies.
package epx_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int POS_BITS = 32;
    localparam int ERR_BITS = 16;
    localparam int DEB_BITS = 8;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [31:0] MAX_COUNT_RESET = 32'd65535;
    localparam logic [DEB_BITS-1:0] DEBOUNCE_RESET = 8'd100;
    localparam logic [DEB_BITS-1:0] DEBOUNCE_MAX = 8'hFF;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_COUNT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_USE_INDEX = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOMING_MODE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_PIN_EN = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_LEN = 3'd4;

    localparam logic [1:0] HOME_NONE = 2'd0;
    localparam logic [1:0] HOME_LIMIT = 2'd1;
    localparam logic [1:0] HOME_MANUAL = 2'd2;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_ROLL = 1'b1;

    typedef struct packed {
        logic                use_index;
        logic [1:0]          homing_mode;
        logic                zero_pin_enable;
        logic [DEB_BITS-1:0] debounce_length;
    } cfg_t;

    typedef struct packed {
        logic cmd;
        logic count_up;
        logic index_seen;
        logic count_error;
        logic limit_switch;
        logic calib_flag;
        logic zero_pin;
    } flags_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0] position;
        logic [ERR_BITS-1:0]        error_count;
        logic                       is_calibrated;
        logic                       clear_hw_counter;
    } result_t;

endpackage

[src/encoder_position_extender_with_homing.sv]
// Top level of the encoder position extender: input register, core, result register.
// Depends on epx_pkg, epx_cfg and epx_core.
//
// The block turns a wrapping hardware quadrature count into a signed 32-bit position
// and homes it by limit switch, manual flag or debounced zero pin. Every input beat
// produces exactly one result beat. A beat is captured in an input register, the core
// computes the result combinationally and registers its updated state, and the result
// sits in an output register, so a new beat is taken every cycle while not stalled. The
// block only stalls input when the result register is full and the consumer holds
// out_ready low. Configuration writes take effect at the next clock edge.
module encoder_position_extender_with_homing #(
    parameter int COUNT_BITS = epx_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [epx_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COUNT_BITS-1:0]            cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cmd,
    input  logic [COUNT_BITS-1:0]            hw_count,
    input  logic                             count_up,
    input  logic                             index_seen,
    input  logic                             count_error,
    input  logic                             limit_switch,
    input  logic                             calib_flag,
    input  logic                             zero_pin,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [epx_pkg::POS_BITS-1:0] position,
    output logic [epx_pkg::ERR_BITS-1:0]     error_count,
    output logic                             is_calibrated,
    output logic                             clear_hw_counter
);

    logic                  in_valid_reg;
    epx_pkg::flags_t       flags_reg;
    logic [COUNT_BITS-1:0] hw_count_reg;
    logic                  out_valid_reg;
    epx_pkg::result_t      result_reg;
    epx_pkg::result_t      result_next;
    epx_pkg::cfg_t         cfg;
    logic [COUNT_BITS-1:0] max_count;
    logic                  advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    epx_cfg #(
        .COUNT_BITS(COUNT_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .max_count (max_count),
        .cfg       (cfg)
    );

    epx_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .max_count (max_count),
        .cfg       (cfg),
        .flags     (flags_reg),
        .hw_count  (hw_count_reg),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            flags_reg.cmd          <= cmd;
            flags_reg.count_up     <= count_up;
            flags_reg.index_seen   <= index_seen;
            flags_reg.count_error  <= count_error;
            flags_reg.limit_switch <= limit_switch;
            flags_reg.calib_flag   <= calib_flag;
            flags_reg.zero_pin     <= zero_pin;
            hw_count_reg           <= hw_count;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign position         = result_reg.position;
    assign error_count      = result_reg.error_count;
    assign is_calibrated    = result_reg.is_calibrated;
    assign clear_hw_counter = result_reg.clear_hw_counter;

endmodule

[src/epx_cfg.sv]
// Configuration register file of the encoder position extender.
// Depends on epx_pkg.
module epx_cfg #(
    parameter int COUNT_BITS = epx_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [epx_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COUNT_BITS-1:0]           cfg_data,
    output logic [COUNT_BITS-1:0]           max_count,
    output epx_pkg::cfg_t                   cfg
);

    logic [COUNT_BITS-1:0] max_count_reg;
    epx_pkg::cfg_t         cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_count_reg           <= epx_pkg::MAX_COUNT_RESET[COUNT_BITS-1:0];
            cfg_reg.use_index       <= 1'b0;
            cfg_reg.homing_mode     <= epx_pkg::HOME_NONE;
            cfg_reg.zero_pin_enable <= 1'b0;
            cfg_reg.debounce_length <= epx_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                epx_pkg::CFG_MAX_COUNT:    max_count_reg <= cfg_data;
                epx_pkg::CFG_USE_INDEX:    cfg_reg.use_index <= cfg_data[0];
                epx_pkg::CFG_HOMING_MODE:  cfg_reg.homing_mode <= cfg_data[1:0];
                epx_pkg::CFG_ZERO_PIN_EN:  cfg_reg.zero_pin_enable <= cfg_data[0];
                epx_pkg::CFG_DEBOUNCE_LEN:
                    cfg_reg.debounce_length <= cfg_data[epx_pkg::DEB_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign max_count = max_count_reg;
    assign cfg       = cfg_reg;

endmodule

[src/epx_core.sv]
// Position, roll, error, homing and debounce state with its update logic.
// Depends on epx_pkg.
module epx_core #(
    parameter int COUNT_BITS = epx_pkg::COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic [COUNT_BITS-1:0] max_count,
    input  epx_pkg::cfg_t         cfg,
    input  epx_pkg::flags_t       flags,
    input  logic [COUNT_BITS-1:0] hw_count,
    output epx_pkg::result_t      result
);

    localparam int PB = epx_pkg::POS_BITS;
    localparam int DB = epx_pkg::DEB_BITS;

    logic [PB-1:0]                 roll_reg, roll_next;
    logic [PB-1:0]                 pos_reg, pos_next;
    logic [epx_pkg::ERR_BITS-1:0]  err_reg, err_next;
    logic                          armed_reg, armed_next;
    logic                          prev_calib_reg, prev_calib_next;
    logic                          prev_lim_reg, prev_lim_next;
    logic                          prev_man_reg, prev_man_next;
    logic                          cal_reg, cal_next;
    logic [DB-1:0]                 deb_reg, deb_next;

    logic [PB-1:0] span;
    logic [PB-1:0] count32;
    logic [PB-1:0] roll_step;
    logic [PB-1:0] roll_home;
    logic          armed_mid;
    logic          home_fire;
    logic          zero_fire;

    assign span      = PB'(max_count) + PB'(1);
    assign count32   = PB'(hw_count);
    assign roll_step = flags.count_up ? (roll_reg + span) : (roll_reg - span);

    always_comb
    begin
        roll_next       = roll_reg;
        pos_next        = pos_reg;
        err_next        = err_reg;
        armed_next      = armed_reg;
        prev_calib_next = prev_calib_reg;
        prev_lim_next   = prev_lim_reg;
        prev_man_next   = prev_man_reg;
        cal_next        = cal_reg;
        deb_next        = deb_reg;
        armed_mid       = armed_reg;
        home_fire       = 1'b0;
        zero_fire       = 1'b0;
        roll_home       = roll_reg;

        if (flags.cmd == epx_pkg::CMD_ROLL)
        begin
            if (!cfg.use_index || flags.index_seen)
            begin
                roll_next = roll_step;
                pos_next  = roll_step + count32;
            end
            if (flags.count_error)
            begin
                err_next = err_reg + 1'b1;
            end
        end
        else
        begin
            case (cfg.homing_mode)
                epx_pkg::HOME_LIMIT:
                begin
                    if (!armed_reg)
                    begin
                        armed_mid = flags.calib_flag && !prev_calib_reg;
                    end
                    home_fire  = armed_mid && flags.limit_switch && !prev_lim_reg;
                    armed_next = armed_mid && !home_fire;
                end
                epx_pkg::HOME_MANUAL:
                    home_fire = flags.calib_flag && !prev_man_reg;
                default: ;
            endcase
            if (home_fire)
            begin
                cal_next = 1'b1;
            end
            prev_lim_next   = flags.limit_switch;
            prev_calib_next = flags.calib_flag;
            prev_man_next   = flags.calib_flag;

            roll_home = home_fire ? '0 : roll_reg;
            roll_next = roll_home;
            pos_next  = home_fire ? '0 : (roll_reg + count32);

            if (cfg.zero_pin_enable)
            begin
                if (!flags.zero_pin)
                begin
                    deb_next = '0;
                end
                else if (deb_reg != epx_pkg::DEBOUNCE_MAX)
                begin
                    deb_next = deb_reg + 1'b1;
                end
                zero_fire = (deb_next >= cfg.debounce_length);
                if (zero_fire)
                begin
                    roll_next = '0;
                    pos_next  = '0;
                end
            end
            else
            begin
                deb_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_reg       <= '0;
            pos_reg        <= '0;
            err_reg        <= '0;
            armed_reg      <= 1'b0;
            prev_calib_reg <= 1'b0;
            prev_lim_reg   <= 1'b1;
            prev_man_reg   <= 1'b0;
            cal_reg        <= 1'b0;
            deb_reg        <= '0;
        end
        else if (advance)
        begin
            roll_reg       <= roll_next;
            pos_reg        <= pos_next;
            err_reg        <= err_next;
            armed_reg      <= armed_next;
            prev_calib_reg <= prev_calib_next;
            prev_lim_reg   <= prev_lim_next;
            prev_man_reg   <= prev_man_next;
            cal_reg        <= cal_next;
            deb_reg        <= deb_next;
        end
    end

    assign result.position         = pos_next;
    assign result.error_count      = err_next;
    assign result.is_calibrated    = cal_next;
    assign result.clear_hw_counter = (flags.cmd == epx_pkg::CMD_STEP)
                                     && (home_fire || zero_fire);

endmodule

[src/epx_checker.sv]
// Port-level checker for the encoder position extender, bound to its top level.
// Depends on epx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module epx_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [epx_pkg::POS_BITS-1:0] position,
    input logic                                is_calibrated,
    input logic                                clear_hw_counter
);

    logic seen_cal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_cal_reg <= 1'b0;
        end
        else if (out_valid && out_ready && is_calibrated)
        begin
            seen_cal_reg <= 1'b1;
        end
    end

    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
    `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(position))
    `ASSERT_IMPLY(a_clear_zero, clk, rst_n, out_valid && clear_hw_counter, position == 0)
    `ASSERT_IMPLY(a_cal_sticky, clk, rst_n, out_valid && seen_cal_reg, is_calibrated)
    `ASSERT_IMPLY(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready)

endmodule

bind encoder_position_extender_with_homing epx_checker u_epx_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .position         (position),
    .is_calibrated    (is_calibrated),
    .clear_hw_counter (clear_hw_counter)
);

[dv/tb.sv]
// Self-checking testbench for encoder_position_extender_with_homing.
// It drives valid/ready beats, predicts every result with its own position tracker
// and compares it field by field. It depends on epx_pkg and the RTL top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = epx_pkg::COUNT_BITS_DEF;

    typedef struct packed {
        logic          cmd;
        logic [CW-1:0] hw_count;
        logic          count_up;
        logic          index_seen;
        logic          count_error;
        logic          limit_switch;
        logic          calib_flag;
        logic          zero_pin;
    } enc_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [epx_pkg::CFG_IDX_BITS-1:0] cfg_index = epx_pkg::CFG_MAX_COUNT;
    logic [CW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic cmd = epx_pkg::CMD_STEP;
    logic [CW-1:0] hw_count = '0;
    logic count_up = 1'b0;
    logic index_seen = 1'b0;
    logic count_error = 1'b0;
    logic limit_switch = 1'b0;
    logic calib_flag = 1'b0;
    logic zero_pin = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [epx_pkg::POS_BITS-1:0] position;
    logic [epx_pkg::ERR_BITS-1:0] error_count;
    logic is_calibrated;
    logic clear_hw_counter;

    encoder_position_extender_with_homing u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .hw_count         (hw_count),
        .count_up         (count_up),
        .index_seen       (index_seen),
        .count_error      (count_error),
        .limit_switch     (limit_switch),
        .calib_flag       (calib_flag),
        .zero_pin         (zero_pin),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .position         (position),
        .error_count      (error_count),
        .is_calibrated    (is_calibrated),
        .clear_hw_counter (clear_hw_counter)
    );

    always #1 clk = ~clk;

    // Shadow copy of the configuration registers.
    logic [CW-1:0] cfg_max_count = 16'hFFFF;
    logic cfg_use_index = 1'b0;
    logic [1:0] cfg_homing_mode = epx_pkg::HOME_NONE;
    logic cfg_zero_pin_en = 1'b0;
    logic [epx_pkg::DEB_BITS-1:0] cfg_debounce_len = epx_pkg::DEBOUNCE_RESET;

    // Tracker state of the position extender.
    logic [epx_pkg::POS_BITS-1:0] roll_acc = '0;
    logic [epx_pkg::POS_BITS-1:0] pos_acc = '0;
    logic [epx_pkg::ERR_BITS-1:0] err_tally = '0;
    logic homing_armed = 1'b0;
    logic last_calib = 1'b0;
    logic last_limit = 1'b1;
    logic last_manual = 1'b0;
    logic homed = 1'b0;
    logic [epx_pkg::DEB_BITS-1:0] zero_pin_run = '0;

    enc_beat_t pending_beats[$];
    epx_pkg::result_t expected_results[$];
    enc_beat_t beat_on_bus;
    epx_pkg::result_t oldest_result;
    int mismatches = 0;
    bit gaps_on = 1'b1;
    logic lim_lvl = 1'b0;
    logic cal_lvl = 1'b0;
    logic zp_lvl = 1'b0;

    function automatic epx_pkg::result_t track_position(input enc_beat_t b);
        epx_pkg::result_t r;
        logic [epx_pkg::POS_BITS-1:0] span;
        logic [CW-1:0] cnt;
        logic zeroed;
        span = 32'(cfg_max_count) + 32'd1;
        cnt = b.hw_count;
        zeroed = 1'b0;
        if (b.cmd == epx_pkg::CMD_ROLL)
        begin
            if (!cfg_use_index || b.index_seen)
            begin
                roll_acc = b.count_up ? roll_acc + span : roll_acc - span;
                pos_acc = roll_acc + 32'(cnt);
            end
            if (b.count_error)
                err_tally = err_tally + 16'd1;
        end
        else
        begin
            if (cfg_homing_mode == epx_pkg::HOME_LIMIT)
            begin
                if (!homing_armed)
                    homing_armed = b.calib_flag && !last_calib;
                if (homing_armed && b.limit_switch && !last_limit)
                begin
                    zeroed = 1'b1;
                    homed = 1'b1;
                    homing_armed = 1'b0;
                end
            end
            else if (cfg_homing_mode == epx_pkg::HOME_MANUAL)
            begin
                if (b.calib_flag && !last_manual)
                begin
                    zeroed = 1'b1;
                    homed = 1'b1;
                end
            end
            last_limit = b.limit_switch;
            last_calib = b.calib_flag;
            last_manual = b.calib_flag;
            if (zeroed)
            begin
                roll_acc = '0;
                cnt = '0;
            end
            pos_acc = roll_acc + 32'(cnt);
            if (cfg_zero_pin_en)
            begin
                if (b.zero_pin)
                begin
                    if (zero_pin_run != epx_pkg::DEBOUNCE_MAX)
                        zero_pin_run = zero_pin_run + 8'd1;
                end
                else
                    zero_pin_run = '0;
                if (zero_pin_run >= cfg_debounce_len)
                begin
                    zeroed = 1'b1;
                    roll_acc = '0;
                    pos_acc = '0;
                end
            end
            else
                zero_pin_run = '0;
        end
        r.position = pos_acc;
        r.error_count = err_tally;
        r.is_calibrated = homed;
        r.clear_hw_counter = zeroed;
        return r;
    endfunction

    function automatic enc_beat_t make_beat(input logic c, input logic [CW-1:0] n,
                                            input logic up, input logic idx,
                                            input logic err, input logic lim,
                                            input logic cal, input logic zp);
        enc_beat_t b;
        b.cmd = c;
        b.hw_count = n;
        b.count_up = up;
        b.index_seen = idx;
        b.count_error = err;
        b.limit_switch = lim;
        b.calib_flag = cal;
        b.zero_pin = zp;
        return b;
    endfunction

    // Input driver: predicts on acceptance, then loads the next beat or idles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_results.push_back(track_position(beat_on_bus));
            if (!in_valid || in_ready)
            begin
                if (pending_beats.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 23))
                begin
                    beat_on_bus = pending_beats.pop_front();
                    in_valid <= 1'b1;
                    cmd <= beat_on_bus.cmd;
                    hw_count <= beat_on_bus.hw_count;
                    count_up <= beat_on_bus.count_up;
                    index_seen <= beat_on_bus.index_seen;
                    count_error <= beat_on_bus.count_error;
                    limit_switch <= beat_on_bus.limit_switch;
                    calib_flag <= beat_on_bus.calib_flag;
                    zero_pin <= beat_on_bus.zero_pin;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each accepted beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result beat with no prediction: position %0d errors %0d",
                                 position, error_count);
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (position !== oldest_result.position
                        || error_count !== oldest_result.error_count
                        || is_calibrated !== oldest_result.is_calibrated
                        || clear_hw_counter !== oldest_result.clear_hw_counter)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch: expected pos %0d err %0d cal %0b clr %0b,",
                                      " got pos %0d err %0d cal %0b clr %0b"},
                                     $signed(oldest_result.position),
                                     oldest_result.error_count,
                                     oldest_result.is_calibrated,
                                     oldest_result.clear_hw_counter,
                                     position, error_count, is_calibrated,
                                     clear_hw_counter);
                    end
                end
            end
            out_ready <= !(gaps_on && $urandom_range(0, 99) < 23);
        end
    end

    task automatic write_reg(input logic [epx_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [CW-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            epx_pkg::CFG_MAX_COUNT: cfg_max_count = val;
            epx_pkg::CFG_USE_INDEX: cfg_use_index = val[0];
            epx_pkg::CFG_HOMING_MODE: cfg_homing_mode = val[1:0];
            epx_pkg::CFG_ZERO_PIN_EN: cfg_zero_pin_en = val[0];
            epx_pkg::CFG_DEBOUNCE_LEN: cfg_debounce_len = val[epx_pkg::DEB_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [CW-1:0] max_cnt, input logic use_idx,
                                 input logic [1:0] mode, input logic zp_en,
                                 input logic [epx_pkg::DEB_BITS-1:0] deb_len);
        wait_drained();
        write_reg(epx_pkg::CFG_MAX_COUNT, max_cnt);
        write_reg(epx_pkg::CFG_USE_INDEX, CW'(use_idx));
        write_reg(epx_pkg::CFG_HOMING_MODE, CW'(mode));
        write_reg(epx_pkg::CFG_ZERO_PIN_EN, CW'(zp_en));
        write_reg(epx_pkg::CFG_DEBOUNCE_LEN, CW'(deb_len));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random beats with slowly toggling switch, flag and pin levels so that
    // edges, arming and debounce runs all occur.
    task automatic queue_random(input int n, input bit zp_high);
        logic [CW-1:0] n_val;
        logic c;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                lim_lvl = ~lim_lvl;
            if ($urandom_range(0, 3) == 0)
                cal_lvl = ~cal_lvl;
            if ($urandom_range(0, 15) == 0)
                zp_lvl = ~zp_lvl;
            case ($urandom_range(0, 7))
                0: n_val = '0;
                1: n_val = '1;
                default: n_val = CW'($urandom);
            endcase
            if (zp_high)
                c = ($urandom_range(0, 7) == 0) ? epx_pkg::CMD_ROLL : epx_pkg::CMD_STEP;
            else
                c = $urandom_range(0, 1) ? epx_pkg::CMD_ROLL : epx_pkg::CMD_STEP;
            pending_beats.push_back(make_beat(c, n_val, 1'($urandom), 1'($urandom),
                                              1'($urandom), lim_lvl, cal_lvl,
                                              zp_high ? 1'b1 : zp_lvl));
        end
    endtask

    function automatic logic [CW-1:0] pick_max_count();
        case ($urandom_range(0, 3))
            0: return 16'd1;
            1: return 16'hFFFF;
            2: return CW'($urandom_range(1, 16));
            default: return CW'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [epx_pkg::DEB_BITS-1:0] pick_debounce();
        case ($urandom_range(0, 3))
            0: return 8'd1;
            1: return 8'd255;
            2: return 8'($urandom_range(1, 8));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        apply_setting(16'hFFFF, 1'b0, epx_pkg::HOME_NONE, 1'b0, epx_pkg::DEBOUNCE_RESET);
        pending_beats.push_back(make_beat(epx_pkg::CMD_STEP, 16'h0000,
                                          1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(epx_pkg::CMD_STEP, 16'hFFFF,
                                          1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(epx_pkg::CMD_ROLL, 16'h0000,
                                          1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(epx_pkg::CMD_ROLL, 16'hFFFF,
                                          1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(epx_pkg::CMD_ROLL, 16'hFFFF,
                                          1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(epx_pkg::CMD_STEP, 16'h1234,
                                          1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
        pending_beats.push_back(make_beat(epx_pkg::CMD_STEP, 16'h8001,
                                          1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));

        apply_setting(16'd1, 1'b1, epx_pkg::HOME_LIMIT, 1'b1, 8'd1);
        pending_beats.push_back(make_beat(epx_pkg::CMD_ROLL, 16'h0001,
                                          1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(epx_pkg::CMD_ROLL, 16'h0001,
                                          1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(epx_pkg::CMD_STEP, 16'h0001,
                                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(epx_pkg::CMD_STEP, 16'h0001,
                                          1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(epx_pkg::CMD_STEP, 16'h0001,
                                          1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        pending_beats.push_back(make_beat(epx_pkg::CMD_STEP, 16'h0001,
                                          1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        pending_beats.push_back(make_beat(epx_pkg::CMD_STEP, 16'h0001,
                                          1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        pending_beats.push_back(make_beat(epx_pkg::CMD_STEP, 16'h0001,
                                          1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));

        apply_setting(16'd0, 1'b0, epx_pkg::HOME_MANUAL, 1'b1, 8'd0);
        pending_beats.push_back(make_beat(epx_pkg::CMD_ROLL, 16'h0005,
                                          1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(epx_pkg::CMD_ROLL, 16'h0005,
                                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(epx_pkg::CMD_STEP, 16'h0007,
                                          1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        pending_beats.push_back(make_beat(epx_pkg::CMD_STEP, 16'h0007,
                                          1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));

        apply_setting(16'hFFFF, 1'b0, 2'd3, 1'b0, 8'd255);
        pending_beats.push_back(make_beat(epx_pkg::CMD_STEP, 16'h0003,
                                          1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        pending_beats.push_back(make_beat(epx_pkg::CMD_STEP, 16'h0003,
                                          1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));

        for (int p = 0; p < 5; p++)
        begin
            apply_setting(pick_max_count(), 1'($urandom), 2'($urandom_range(0, 3)),
                          1'($urandom), pick_debounce());
            gaps_on = (p != 2);
            queue_random(100, 1'b0);
        end

        apply_setting(pick_max_count(), 1'($urandom), 2'($urandom_range(0, 3)),
                      1'b1, 8'd255);
        gaps_on = 1'b1;
        queue_random(200, 1'b1);

        // Run of counted errors and mostly backward rollovers: the position
        // wraps below zero into negative values.
        apply_setting(16'hFFFF, 1'b0, 2'($urandom_range(0, 3)), 1'b0, pick_debounce());
        for (int i = 0; i < 80; i++)
            pending_beats.push_back(make_beat(epx_pkg::CMD_ROLL, CW'($urandom),
                                              $urandom_range(0, 9) == 0, 1'($urandom),
                                              1'b1, 1'($urandom), 1'($urandom),
                                              1'($urandom)));

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
